FILE: rtl/pfd_pkg.sv
`default_nettype none

package pfd_pkg;

    localparam int SqSide     = 5;
    localparam int SqCells    = 25;
    localparam int AlphaCount = 26;

    localparam logic [7:0] LowerA  = 8'd97;
    localparam logic [7:0] LowerZ  = 8'd122;
    localparam logic [7:0] UpperLo = 8'd64;
    localparam logic [7:0] UpperHi = 8'd91;
    localparam logic [7:0] CaseGap = 8'd32;
    localparam logic [4:0] LetterJ = 5'd9;
    localparam logic [4:0] LetterI = 5'd8;

    typedef enum logic [1:0] {
        CMD_CLEAR    = 2'd0,
        CMD_KEY      = 2'd1,
        CMD_COMPLETE = 2'd2,
        CMD_DECRYPT  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_SCAN,
        S_WAIT,
        S_RD1,
        S_RD2,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } t_fold;

    function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
        return 5'({row, 2'b00}) + 5'(row) + 5'(col);
    endfunction

    function automatic logic [2:0] dec_wrap(input logic [2:0] v);
        return (v == 3'd0) ? 3'(SqSide - 1) : v - 3'd1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pfd_fold.sv
`default_nettype none

module pfd_fold
    import pfd_pkg::*;
(
    input  wire logic [7:0] i_char,
    output t_fold           o_fold
);

    logic [7:0] lc;
    logic [7:0] off;

    always_comb begin
        lc = i_char;
        if (i_char > UpperLo && i_char < UpperHi) begin
            lc = i_char + CaseGap;
        end
        off         = lc - LowerA;
        o_fold.ok   = (lc >= LowerA) && (lc <= LowerZ);
        o_fold.idx  = (off[4:0] == LetterJ) ? LetterI : off[4:0];
    end

endmodule

`default_nettype wire

FILE: rtl/playfair_digraph_decrypter.sv
`default_nettype none
// Channel   Ports                                          Handshake
// command   i_command, i_char_first, i_char_second         start & !busy
// result    o_plain_first, o_plain_second, o_status        o_strobe, one cycle
//
// Clear and key letter never leave idle; complete is busy in S_FILL, one letter a cycle.
// A decrypt is busy for a 25-entry scan through the single read port, a wait for the
// registered read, two lookups and an emit; its result strobes next cycle.
// A decrypt that fails early (square not ready, non-letter) strobes next cycle.
// Reset is synchronous and clears the used letters, fill count and ready flag.
// The receiver cannot stall; results are never held.

module playfair_digraph_decrypter
    import pfd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_command,
    input  wire logic [7:0] i_char_first,
    input  wire logic [7:0] i_char_second,
    output logic            o_strobe,
    output logic [7:0]      o_plain_first,
    output logic [7:0]      o_plain_second,
    output logic            o_status
);

    t_state r_state, n_state;

    logic [4:0] r_mem [SqCells];
    logic [4:0] r_rd_data;

    logic [AlphaCount-1:0] r_used;
    logic [4:0]            r_fill;
    logic                  r_ready;
    logic [4:0]            r_k;
    logic [4:0]            r_idx;
    logic [2:0]            r_row, r_col;
    logic                  r_tag_vld;
    logic [2:0]            r_tag_row, r_tag_col;
    logic [4:0]            r_a, r_b;
    logic                  r_fa_ok, r_fb_ok;
    logic [2:0]            r_fa_row, r_fa_col, r_fb_row, r_fb_col;
    logic [4:0]            r_p1;
    logic                  r_strobe;
    logic [7:0]            r_out_first, r_out_second;
    logic                  r_status;

    t_fold fold_a, fold_b;
    t_cmd  cmd;

    logic       mem_we;
    logic [4:0] mem_wdata;
    logic [4:0] rd_addr;
    logic       emit_ok;
    logic       emit_err;
    logic       key_ok;
    logic [7:0] key_off;
    logic [4:0] o1, o2;
    logic       accept;

    pfd_fold u_fold_a (.i_char(i_char_first),  .o_fold(fold_a));
    pfd_fold u_fold_b (.i_char(i_char_second), .o_fold(fold_b));

    assign cmd     = t_cmd'(i_command);
    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign key_off = i_char_first - LowerA;
    assign key_ok  = (i_char_first >= LowerA) && (i_char_first <= LowerZ)
                     && (key_off[4:0] != LetterJ) && !r_used[key_off[4:0]]
                     && (r_fill < 5'(SqCells));

    always_comb begin
        if (r_fa_row == r_fb_row) begin
            o1 = cell_addr(r_fa_row, dec_wrap(r_fa_col));
            o2 = cell_addr(r_fb_row, dec_wrap(r_fb_col));
        end else if (r_fa_col == r_fb_col) begin
            o1 = cell_addr(dec_wrap(r_fa_row), r_fa_col);
            o2 = cell_addr(dec_wrap(r_fb_row), r_fb_col);
        end else begin
            o1 = cell_addr(r_fa_row, r_fb_col);
            o2 = cell_addr(r_fb_row, r_fa_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_wdata = r_k;
        rd_addr   = r_idx;
        emit_ok   = 1'b0;
        emit_err  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (cmd)
                        CMD_CLEAR: begin
                        end
                        CMD_KEY: begin
                            if (key_ok) begin
                                mem_we    = 1'b1;
                                mem_wdata = key_off[4:0];
                            end
                        end
                        CMD_COMPLETE: n_state = S_FILL;
                        CMD_DECRYPT: begin
                            if (r_ready && fold_a.ok && fold_b.ok) begin
                                n_state = S_SCAN;
                            end else begin
                                emit_err = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                if (r_k != LetterJ && !r_used[r_k] && r_fill < 5'(SqCells)) begin
                    mem_we = 1'b1;
                end
                if (r_k == 5'(AlphaCount - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_idx == 5'(SqCells - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: n_state = S_RD1;
            S_RD1: begin
                rd_addr = o1;
                if (r_fa_ok && r_fb_ok) begin
                    n_state = S_RD2;
                end else begin
                    emit_err = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RD2: begin
                rd_addr = o2;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                emit_ok = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // square store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_fill    <= '0;
            r_ready   <= 1'b0;
            r_tag_vld <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe  <= emit_ok || emit_err;
            r_tag_vld <= (r_state == S_SCAN);
            if (mem_we) begin
                r_fill            <= r_fill + 5'd1;
                r_used[mem_wdata] <= 1'b1;
            end
            if (accept && cmd == CMD_CLEAR) begin
                r_used  <= '0;
                r_fill  <= '0;
                r_ready <= 1'b0;
            end
            if (r_state == S_FILL && n_state == S_IDLE) begin
                r_ready <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= (r_state == S_FILL) ? r_k + 5'd1 : '0;
        r_tag_row <= r_row;
        r_tag_col <= r_col;
        if (r_state == S_SCAN) begin
            r_idx <= r_idx + 5'd1;
            if (r_col == 3'(SqSide - 1)) begin
                r_col <= '0;
                r_row <= r_row + 3'd1;
            end else begin
                r_col <= r_col + 3'd1;
            end
        end else begin
            r_idx <= '0;
            r_row <= '0;
            r_col <= '0;
        end

        if (accept) begin
            r_a     <= fold_a.idx;
            r_b     <= fold_b.idx;
            r_fa_ok <= 1'b0;
            r_fb_ok <= 1'b0;
        end else if (r_tag_vld) begin
            if (!r_fa_ok && r_rd_data == r_a) begin
                r_fa_ok  <= 1'b1;
                r_fa_row <= r_tag_row;
                r_fa_col <= r_tag_col;
            end
            if (!r_fb_ok && r_rd_data == r_b) begin
                r_fb_ok  <= 1'b1;
                r_fb_row <= r_tag_row;
                r_fb_col <= r_tag_col;
            end
        end

        if (r_state == S_RD2) begin
            r_p1 <= r_rd_data;
        end
        if (emit_err) begin
            r_out_first  <= '0;
            r_out_second <= '0;
            r_status     <= 1'b1;
        end else if (emit_ok) begin
            r_out_first  <= 8'(r_p1) + LowerA;
            r_out_second <= 8'(r_rd_data) + LowerA;
            r_status     <= 1'b0;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_plain_first  = r_out_first;
    assign o_plain_second = r_out_second;
    assign o_status       = r_status;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'(SqCells))
        else $error("fill count past square size");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_fill == 5'(SqCells)))
        else $error("square ready but not full");

    a_ok_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_status) |-> $past(r_state == S_EMIT))
        else $error("ok result without lookup");

    a_fill_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && r_k == 5'(AlphaCount - 1)) |=> (r_ready && r_state == S_IDLE))
        else $error("complete did not mark square ready");

    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD1) |-> (r_fa_ok && r_fb_ok))
        else $error("letter missing from full square");

endmodule

`default_nettype wire

FILE: dv/tb_playfair_digraph_decrypter.sv
module tb_playfair_digraph_decrypter;
    timeunit 1ns;
    timeprecision 1ps;

    import pfd_pkg::*;

    localparam int ItemTarget = 1500;
    localparam int QuietTail  = 150;
    localparam int StallLimit = 400;
    localparam int DrainWait  = 40;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] c1;
        logic [7:0] c2;
    } t_item;

    typedef struct packed {
        logic [7:0] pf;
        logic [7:0] ps;
        logic       st;
    } t_plain;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_command = CMD_CLEAR;
    logic [7:0] i_char_first = 8'h00;
    logic [7:0] i_char_second = 8'h00;
    logic       o_strobe;
    logic [7:0] o_plain_first;
    logic [7:0] o_plain_second;
    logic       o_status;

    t_item  cmd_backlog[$];
    t_plain plain_due[$];

    // shadow copy of the key square
    logic [4:0] sq_shadow [SqCells];
    logic       used_shadow [AlphaCount];
    int         fill_shadow = 0;
    bit         ready_shadow = 1'b0;

    bit item_taken = 1'b0;
    int gap_left = 0;
    int gap_pct = 20;
    int stall_cycles = 0;
    int mismatches = 0;
    int n_items = 0;
    int n_results = 0;
    int n_row = 0;
    int n_col = 0;
    int n_rect = 0;
    int n_notfound = 0;
    int n_squares = 0;

    playfair_digraph_decrypter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_char_first   (i_char_first),
        .i_char_second  (i_char_second),
        .o_strobe       (o_strobe),
        .o_plain_first  (o_plain_first),
        .o_plain_second (o_plain_second),
        .o_status       (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic void push_item(input t_cmd c, input logic [7:0] a, input logic [7:0] b);
        t_item it;
        it.cmd = c;
        it.c1 = a;
        it.c2 = b;
        cmd_backlog.push_back(it);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_cipher_char();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return rand_byte();
        if (r == 1) return $urandom_range(0, 1) ? "J" : "j";
        if (r < 8) return 8'(UpperLo + 1 + $urandom_range(0, 25));
        return 8'(LowerA + $urandom_range(0, 25));
    endfunction

    // letter index with case folding and j read as i; AlphaCount if not a letter
    function automatic logic [4:0] fold_char(input logic [7:0] c);
        logic [7:0] lc;
        lc = c;
        if (lc > UpperLo && lc < UpperHi) lc = lc + CaseGap;
        if (lc < LowerA || lc > LowerZ) return 5'(AlphaCount);
        lc = lc - LowerA;
        if (lc[4:0] == LetterJ) return LetterI;
        return lc[4:0];
    endfunction

    function automatic int cell_of(input logic [4:0] idx);
        for (int k = 0; k < fill_shadow; k++) begin
            if (sq_shadow[k] == idx) return k;
        end
        return SqCells;
    endfunction

    function automatic void place_letter(input logic [4:0] idx);
        if (fill_shadow < SqCells) begin
            sq_shadow[fill_shadow] = idx;
            fill_shadow++;
            used_shadow[idx] = 1'b1;
        end
    endfunction

    function automatic void wipe_square();
        foreach (used_shadow[k]) used_shadow[k] = 1'b0;
        fill_shadow = 0;
        ready_shadow = 1'b0;
    endfunction

    // advances the shadow square and queues the plaintext a digraph yields
    function automatic void decipher_item(input t_item it);
        logic [4:0] a, b;
        int pa, pb, r1, c1, r2, c2, o1, o2;
        t_plain res;
        case (it.cmd)
            CMD_CLEAR: begin
                wipe_square();
            end
            CMD_KEY: begin
                if (it.c1 >= LowerA && it.c1 <= LowerZ) begin
                    a = 5'(it.c1 - LowerA);
                    if (a != LetterJ && !used_shadow[a]) place_letter(a);
                end
            end
            CMD_COMPLETE: begin
                for (int k = 0; k < AlphaCount; k++) begin
                    if (5'(k) != LetterJ && !used_shadow[k]) place_letter(5'(k));
                end
                ready_shadow = 1'b1;
                n_squares++;
            end
            default: begin
                a = fold_char(it.c1);
                b = fold_char(it.c2);
                pa = SqCells;
                pb = SqCells;
                if (ready_shadow && a < AlphaCount && b < AlphaCount) begin
                    pa = cell_of(a);
                    pb = cell_of(b);
                end
                if (pa >= SqCells || pb >= SqCells) begin
                    res.pf = 8'h00;
                    res.ps = 8'h00;
                    res.st = 1'b1;
                    n_notfound++;
                end else begin
                    r1 = pa / SqSide;
                    c1 = pa % SqSide;
                    r2 = pb / SqSide;
                    c2 = pb % SqSide;
                    if (r1 == r2) begin
                        o1 = r1 * SqSide + (c1 + SqSide - 1) % SqSide;
                        o2 = r2 * SqSide + (c2 + SqSide - 1) % SqSide;
                        n_row++;
                    end else if (c1 == c2) begin
                        o1 = ((r1 + SqSide - 1) % SqSide) * SqSide + c1;
                        o2 = ((r2 + SqSide - 1) % SqSide) * SqSide + c2;
                        n_col++;
                    end else begin
                        o1 = r1 * SqSide + c2;
                        o2 = r2 * SqSide + c1;
                        n_rect++;
                    end
                    res.pf = 8'(LowerA + sq_shadow[o1]);
                    res.ps = 8'(LowerA + sq_shadow[o2]);
                    res.st = 1'b0;
                end
                plain_due.push_back(res);
            end
        endcase
    endfunction

    always @(negedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && !item_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_backlog.size() == 0) begin
                start <= 1'b0;
            end else if (cmd_backlog.size() > QuietTail && $urandom_range(0, 99) < gap_pct) begin
                gap_left = $urandom_range(1, 10) - 1;
                start <= 1'b0;
            end else begin
                nxt = cmd_backlog.pop_front();
                start <= 1'b1;
                i_command <= nxt.cmd;
                i_char_first <= nxt.c1;
                i_char_second <= nxt.c2;
                if ($urandom_range(0, 39) == 0) begin
                    case ($urandom_range(0, 3))
                        0, 1: gap_pct = 0;
                        2: gap_pct = 20;
                        default: gap_pct = 50;
                    endcase
                end
            end
        end
        item_taken = 1'b0;
    end

    always @(posedge i_clk) begin
        t_plain due;
        t_item seen;
        bit progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (o_strobe) begin
                progress = 1'b1;
                n_results++;
                if (plain_due.size() == 0) begin
                    flag_mismatch("result strobe with no digraph pending");
                end else begin
                    due = plain_due.pop_front();
                    if (o_plain_first !== due.pf)
                        flag_mismatch($sformatf("result %0d plain_first %h, want %h",
                                                n_results, o_plain_first, due.pf));
                    if (o_plain_second !== due.ps)
                        flag_mismatch($sformatf("result %0d plain_second %h, want %h",
                                                n_results, o_plain_second, due.ps));
                    if (o_status !== due.st)
                        flag_mismatch($sformatf("result %0d status %b, want %b",
                                                n_results, o_status, due.st));
                end
            end
            if (start && !busy) begin
                progress = 1'b1;
                item_taken = 1'b1;
                n_items++;
                seen.cmd = t_cmd'(i_command);
                seen.c1 = i_char_first;
                seen.c2 = i_char_second;
                decipher_item(seen);
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("timeout: no item or result for %0d cycles", StallLimit);
                $display("tb_playfair_digraph_decrypter NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] ca, cb;
        wipe_square();

        // directed: square not ready, key handling, each decrypt rule and non-letters
        push_item(CMD_DECRYPT, "a", "b");
        push_item(CMD_KEY, "p", 8'h00);
        push_item(CMD_KEY, "l", 8'h00);
        push_item(CMD_KEY, "a", 8'h00);
        push_item(CMD_KEY, "y", 8'h00);
        push_item(CMD_KEY, "f", 8'h00);
        push_item(CMD_KEY, "a", 8'h00);
        push_item(CMD_KEY, "j", 8'h00);
        push_item(CMD_KEY, "P", 8'hFF);
        push_item(CMD_DECRYPT, "p", "l");
        push_item(CMD_COMPLETE, 8'h00, 8'h00);
        push_item(CMD_COMPLETE, 8'hFF, 8'hFF);
        push_item(CMD_KEY, "z", 8'h00);
        push_item(CMD_DECRYPT, "l", "a");
        push_item(CMD_DECRYPT, "c", "q");
        push_item(CMD_DECRYPT, "p", "x");
        push_item(CMD_DECRYPT, "P", "F");
        push_item(CMD_DECRYPT, "p", "u");
        push_item(CMD_DECRYPT, "j", "J");
        push_item(CMD_DECRYPT, "A", "Z");
        push_item(CMD_DECRYPT, 8'h40, "a");
        push_item(CMD_DECRYPT, "z", 8'h5B);
        push_item(CMD_DECRYPT, 8'h60, 8'h7B);
        push_item(CMD_DECRYPT, 8'h00, 8'hFF);
        push_item(CMD_CLEAR, 8'h00, 8'h00);
        push_item(CMD_DECRYPT, "a", "b");

        while (cmd_backlog.size() < ItemTarget) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4))
                    push_item(t_cmd'($urandom_range(0, 3)), rand_byte(), rand_byte());
            end else begin
                push_item(CMD_CLEAR, rand_byte(), rand_byte());
                repeat ($urandom_range(0, 30)) begin
                    ca = ($urandom_range(0, 7) == 0) ? rand_byte()
                                                     : 8'(LowerA + $urandom_range(0, 25));
                    push_item(CMD_KEY, ca, rand_byte());
                end
                if ($urandom_range(0, 5) == 0)
                    push_item(CMD_DECRYPT, rand_cipher_char(), rand_cipher_char());
                push_item(CMD_COMPLETE, rand_byte(), rand_byte());
                if ($urandom_range(0, 7) == 0)
                    push_item(CMD_COMPLETE, rand_byte(), rand_byte());
                repeat ($urandom_range(5, 40)) begin
                    ca = rand_cipher_char();
                    cb = ($urandom_range(0, 9) == 0) ? ca : rand_cipher_char();
                    if ($urandom_range(0, 19) == 0)
                        push_item(CMD_KEY, 8'(LowerA + $urandom_range(0, 25)), rand_byte());
                    else
                        push_item(CMD_DECRYPT, ca, cb);
                end
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() != 0 || start) @(posedge i_clk);
        while (plain_due.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);

        $display("run: %0d items, %0d squares completed, %0d results checked",
                 n_items, n_squares, n_results);
        $display("digraphs: %0d same row, %0d same column, %0d rectangle, %0d not found",
                 n_row, n_col, n_rect, n_notfound);
        if (mismatches == 0) begin
            $display("tb_playfair_digraph_decrypter OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_playfair_digraph_decrypter NOT OK");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/pfd_pkg.sv
rtl/pfd_fold.sv
rtl/playfair_digraph_decrypter.sv
dv/tb_playfair_digraph_decrypter.sv
